// ===== rtl/core/tcce_pkg.sv =====
// Shared types, constants and the microcode store of the text console character engine.
`timescale 1ns / 1ps

package tcce_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam int KIND_W = 2;
    localparam int CODE_W = 8;
    localparam int IDX_W  = 11;
    localparam int CUR_W  = 11;
    localparam int ATTR_W = 8;
    localparam int CELL_W = ATTR_W + CODE_W;
    localparam int CNT_W  = 4;
    localparam int UPC_W  = 4;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;
    localparam logic [CNT_W-1:0]  TAB_STOP   = 4'd8;

    localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    localparam logic [CODE_W-1:0] CODE_SPACE = 8'h20;
    localparam logic [CODE_W-1:0] CODE_BELL  = 8'd7;
    localparam logic [CODE_W-1:0] CODE_BS    = 8'd8;
    localparam logic [CODE_W-1:0] CODE_TAB   = 8'd9;
    localparam logic [CODE_W-1:0] CODE_LF    = 8'd10;
    localparam logic [CODE_W-1:0] CODE_CR    = 8'd13;
    localparam logic [CODE_W-1:0] CODE_DEL   = 8'd127;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CODE_W-1:0] char_code;
        logic [IDX_W-1:0]  cell_index;
    } t_in_beat;

    typedef struct packed {
        logic [CUR_W-1:0]  cursor_position;
        logic [CELL_W-1:0] cell_data;
        logic              scrolled;
    } t_out_beat;

    typedef enum logic [UPC_W-1:0] {
        U_IDLE  = 4'd0,
        U_PUT   = 4'd1,
        U_BS    = 4'd2,
        U_CR    = 4'd3,
        U_LF    = 4'd4,
        U_TAB0  = 4'd5,
        U_TAB1  = 4'd6,
        U_CHECK = 4'd7,
        U_SC0   = 4'd8,
        U_SC1   = 4'd9,
        U_BLANK = 4'd10,
        U_DONE  = 4'd11,
        U_CLEAR = 4'd12,
        U_READ0 = 4'd13,
        U_READ1 = 4'd14
    } t_upc;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_PUT_CHAR,
        OP_PUT_BLANK,
        OP_BACK,
        OP_CR,
        OP_LF,
        OP_TAB_INIT,
        OP_SCROLL_INIT,
        OP_COPY,
        OP_BLANK,
        OP_CLEAR_INIT,
        OP_READ,
        OP_READ_CAP,
        OP_FINISH
    } t_dop;

    typedef enum logic [2:0] {
        J_NEXT,
        J_GOTO,
        J_DISPATCH,
        J_CNT_MORE,
        J_NO_SCROLL,
        J_COPY_MORE,
        J_BLANK_MORE,
        J_FINISH
    } t_jmp;

    typedef struct packed {
        t_dop op;
        t_jmp jmp;
        t_upc target;
    } t_uword;

    typedef struct packed {
        t_dop op;
        logic accept;
    } t_ctrl;

    typedef struct packed {
        logic need_scroll;
        logic cnt_more;
        logic copy_more;
        logic blank_more;
        logic out_busy;
        logic boot;
    } t_stat;

    function automatic t_uword urom(input t_upc a);
        t_uword w;
        w = '{op: OP_NONE, jmp: J_NEXT, target: U_IDLE};
        case (a)
            U_IDLE:  w = '{op: OP_ACCEPT,      jmp: J_DISPATCH,   target: U_IDLE};
            U_PUT:   w = '{op: OP_PUT_CHAR,    jmp: J_GOTO,       target: U_CHECK};
            U_BS:    w = '{op: OP_BACK,        jmp: J_GOTO,       target: U_CHECK};
            U_CR:    w = '{op: OP_CR,          jmp: J_GOTO,       target: U_CHECK};
            U_LF:    w = '{op: OP_LF,          jmp: J_GOTO,       target: U_CHECK};
            U_TAB0:  w = '{op: OP_TAB_INIT,    jmp: J_NEXT,       target: U_IDLE};
            U_TAB1:  w = '{op: OP_PUT_BLANK,   jmp: J_CNT_MORE,   target: U_TAB1};
            U_CHECK: w = '{op: OP_NONE,        jmp: J_NO_SCROLL,  target: U_DONE};
            U_SC0:   w = '{op: OP_SCROLL_INIT, jmp: J_NEXT,       target: U_IDLE};
            U_SC1:   w = '{op: OP_COPY,        jmp: J_COPY_MORE,  target: U_SC1};
            U_BLANK: w = '{op: OP_BLANK,       jmp: J_BLANK_MORE, target: U_BLANK};
            U_DONE:  w = '{op: OP_FINISH,      jmp: J_FINISH,     target: U_IDLE};
            U_CLEAR: w = '{op: OP_CLEAR_INIT,  jmp: J_GOTO,       target: U_BLANK};
            U_READ0: w = '{op: OP_READ,        jmp: J_NEXT,       target: U_IDLE};
            U_READ1: w = '{op: OP_READ_CAP,    jmp: J_GOTO,       target: U_DONE};
            default: w = '{op: OP_NONE,        jmp: J_GOTO,       target: U_IDLE};
        endcase
        return w;
    endfunction

    function automatic t_upc map_entry(input logic [KIND_W-1:0] kind,
                                       input logic [CODE_W-1:0] code);
        t_upc e;
        e = U_DONE;
        unique case (kind)
            KIND_PUT: begin
                unique case (code) inside
                    CODE_BELL:         e = U_CHECK;
                    CODE_BS, CODE_DEL: e = U_BS;
                    CODE_TAB:          e = U_TAB0;
                    CODE_LF:           e = U_LF;
                    CODE_CR:           e = U_CR;
                    default:           e = U_PUT;
                endcase
            end
            KIND_CLEAR: e = U_CLEAR;
            KIND_READ:  e = U_READ0;
            default:    e = U_DONE;
        endcase
        return e;
    endfunction

endpackage

// ===== rtl/core/tcce_sequencer.sv =====
// Microcode sequencer: step counter, control store lookup and jump selection.
`timescale 1ns / 1ps

module tcce_sequencer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  tcce_pkg::t_in_beat i_in,
    input  tcce_pkg::t_stat   i_stat,
    output tcce_pkg::t_ctrl   o_ctrl,
    output logic              o_in_stall
);
    import tcce_pkg::*;

    t_upc   r_upc;
    t_upc   n_upc;
    t_upc   upc_next;
    t_uword uw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= U_CLEAR;
        end else begin
            r_upc <= n_upc;
        end
    end

    always_comb begin
        uw            = urom(r_upc);
        upc_next      = t_upc'(r_upc + 1'b1);
        o_ctrl.op     = uw.op;
        o_ctrl.accept = (r_upc == U_IDLE) && i_in_valid;
        o_in_stall    = (r_upc != U_IDLE);
        n_upc         = r_upc;
        unique case (uw.jmp)
            J_NEXT:       n_upc = upc_next;
            J_GOTO:       n_upc = uw.target;
            J_DISPATCH: begin
                if (i_in_valid) begin
                    n_upc = map_entry(i_in.kind, i_in.char_code);
                end
            end
            J_CNT_MORE:   n_upc = i_stat.cnt_more ? uw.target : upc_next;
            J_NO_SCROLL:  n_upc = i_stat.need_scroll ? upc_next : uw.target;
            J_COPY_MORE:  n_upc = i_stat.copy_more ? uw.target : upc_next;
            J_BLANK_MORE: n_upc = i_stat.blank_more ? uw.target : upc_next;
            J_FINISH: begin
                if (i_stat.boot || !i_stat.out_busy) begin
                    n_upc = U_IDLE;
                end
            end
            default:      n_upc = U_IDLE;
        endcase
    end

endmodule

// ===== rtl/core/tcce_datapath.sv =====
// Datapath: cursor and column registers, loop counters, screen store and result register.
`timescale 1ns / 1ps

module tcce_datapath #(
    parameter int COLUMNS = tcce_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcce_pkg::ROWS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tcce_pkg::t_ctrl               i_ctrl,
    input  tcce_pkg::t_in_beat            i_in,
    input  logic                          i_cfg_we,
    input  logic [tcce_pkg::ATTR_W-1:0]   i_cfg_wdata,
    input  logic                          i_out_stall,
    output tcce_pkg::t_stat               o_stat,
    output logic                          o_out_valid,
    output tcce_pkg::t_out_beat           o_out
);
    import tcce_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int SW    = $clog2(CELLS + 1);
    localparam int CW    = $clog2(CELLS + COLUMNS);
    localparam int CLW   = $clog2(COLUMNS);

    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] r_rdata;

    logic [CW-1:0]     r_cur, n_cur;
    logic [CLW-1:0]    r_col, n_col;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [SW-1:0]     r_src, n_src;
    logic [AW-1:0]     r_dst, n_dst;
    logic              r_boot, n_boot;
    logic              r_out_valid, n_out_valid;
    logic [ATTR_W-1:0] r_attr;
    logic [CODE_W-1:0] r_code, n_code;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [CELL_W-1:0] r_data, n_data;
    logic              r_scrolled, n_scrolled;
    logic              r_rd_ok, n_rd_ok;
    t_out_beat         r_out, n_out;

    logic              we;
    logic [AW-1:0]     waddr;
    logic [CELL_W-1:0] wdata;
    logic [AW-1:0]     raddr;
    logic [CELL_W-1:0] blank;
    logic [CW-1:0]     cur_inc, cur_dec;
    logic [CLW-1:0]    col_inc;
    logic              cur_in;
    logic              out_busy;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ATTR_RESET;
        end else if (i_cfg_we) begin
            r_attr <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= '0;
            r_col       <= '0;
            r_cnt       <= '0;
            r_src       <= '0;
            r_dst       <= '0;
            r_boot      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_cur       <= n_cur;
            r_col       <= n_col;
            r_cnt       <= n_cnt;
            r_src       <= n_src;
            r_dst       <= n_dst;
            r_boot      <= n_boot;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code     <= n_code;
        r_idx      <= n_idx;
        r_data     <= n_data;
        r_scrolled <= n_scrolled;
        r_rd_ok    <= n_rd_ok;
        r_out      <= n_out;
    end

    always_comb begin
        blank    = {(r_boot ? ATTR_RESET : r_attr), CODE_SPACE};
        cur_inc  = r_cur + 1'b1;
        cur_dec  = r_cur - 1'b1;
        col_inc  = (r_col == CLW'(COLUMNS - 1)) ? '0 : r_col + 1'b1;
        cur_in   = (r_cur < CW'(CELLS));
        out_busy = r_out_valid && i_out_stall;

        n_cur       = r_cur;
        n_col       = r_col;
        n_cnt       = r_cnt;
        n_src       = r_src;
        n_dst       = r_dst;
        n_boot      = r_boot;
        n_out_valid = out_busy;
        n_code      = r_code;
        n_idx       = r_idx;
        n_data      = r_data;
        n_scrolled  = r_scrolled;
        n_rd_ok     = r_rd_ok;
        n_out       = r_out;
        we          = 1'b0;
        waddr       = r_cur[AW-1:0];
        wdata       = blank;
        raddr       = r_src[AW-1:0];

        unique case (i_ctrl.op)
            OP_NONE: ;
            OP_ACCEPT: begin
                if (i_ctrl.accept) begin
                    n_code     = i_in.char_code;
                    n_idx      = i_in.cell_index;
                    n_data     = '0;
                    n_scrolled = 1'b0;
                end
            end
            OP_PUT_CHAR: begin
                we    = cur_in;
                wdata = {r_attr, r_code};
                n_cur = cur_inc;
                n_col = col_inc;
            end
            OP_PUT_BLANK: begin
                we    = cur_in;
                n_cur = cur_inc;
                n_col = col_inc;
                n_cnt = r_cnt - 1'b1;
            end
            OP_BACK: begin
                if (r_cur != '0) begin
                    we    = 1'b1;
                    waddr = cur_dec[AW-1:0];
                    n_cur = cur_dec;
                    n_col = (r_col == '0) ? CLW'(COLUMNS - 1) : r_col - 1'b1;
                end
            end
            OP_CR: begin
                n_cur = r_cur - CW'(r_col);
                n_col = '0;
            end
            OP_LF: begin
                n_cur = r_cur + CW'(COLUMNS);
            end
            OP_TAB_INIT: begin
                n_cnt = TAB_STOP - CNT_W'(r_col[2:0]);
            end
            OP_SCROLL_INIT: begin
                n_cur      = r_cur - CW'(COLUMNS);
                n_scrolled = 1'b1;
                raddr      = AW'(COLUMNS);
                n_src      = SW'(COLUMNS + 1);
                n_dst      = '0;
            end
            OP_COPY: begin
                we    = 1'b1;
                waddr = r_dst;
                wdata = r_rdata;
                n_src = r_src + 1'b1;
                n_dst = r_dst + 1'b1;
            end
            OP_BLANK: begin
                we    = 1'b1;
                waddr = r_dst;
                n_dst = r_dst + 1'b1;
            end
            OP_CLEAR_INIT: begin
                n_cur = '0;
                n_col = '0;
                n_dst = '0;
            end
            OP_READ: begin
                raddr   = AW'(r_idx);
                n_rd_ok = (32'(r_idx) < 32'(CELLS));
            end
            OP_READ_CAP: begin
                n_data = r_rd_ok ? r_rdata : '0;
            end
            OP_FINISH: begin
                if (r_boot) begin
                    n_boot = 1'b0;
                end else if (!out_busy) begin
                    n_out_valid = 1'b1;
                    n_out = '{cursor_position: CUR_W'(r_cur),
                              cell_data:       r_data,
                              scrolled:        r_scrolled};
                end
            end
            default: ;
        endcase

        o_stat.need_scroll = !cur_in;
        o_stat.cnt_more    = (r_cnt != CNT_W'(1));
        o_stat.copy_more   = (r_dst != AW'(CELLS - COLUMNS - 1));
        o_stat.blank_more  = (r_dst != AW'(CELLS - 1));
        o_stat.out_busy    = out_busy;
        o_stat.boot        = r_boot;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== rtl/core/text_console_char_engine_unit.sv =====
// Top level of the text console character engine.
// Each beat (a printable byte, CR, LF, backspace, a bell, a read, an unused kind or a tab) gives one
// result; a scroll copies the store up one row and blanks the bottom row, and a clear blanks the
// whole store (one store cell a cycle).
// Handshake: one beat at a time; the next beat can be taken in the cycle in which the result appears.
// Reset: synchronous active low; input then stays stalled while a clearing pass blanks the store with
// attribute 7. Configuration writes are taken at all times.
`timescale 1ns / 1ps

module text_console_char_engine_unit #(
    parameter int COLUMNS = tcce_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcce_pkg::ROWS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  tcce_pkg::t_in_beat          i_in,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output tcce_pkg::t_out_beat         o_out,
    input  logic                        i_cfg_we,
    input  logic [tcce_pkg::ATTR_W-1:0] i_cfg_wdata
);
    import tcce_pkg::*;

    t_ctrl ctrl;
    t_stat stat;

    tcce_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .i_stat     (stat),
        .o_ctrl     (ctrl),
        .o_in_stall (o_in_stall)
    );

    tcce_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

// ===== rtl/core/tcce_checker.sv =====
// Port-level checks of the text console character engine and their binding.
`timescale 1ns / 1ps

module tcce_checker #(
    parameter int COLUMNS = tcce_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcce_pkg::ROWS_DEF
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input tcce_pkg::t_out_beat         o_out
);
    import tcce_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again in the cycle after a beat");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out)))
        else $error("stalled result beat dropped or changed");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((CELLS > 2048) || (int'(o_out.cursor_position) < CELLS)))
        else $error("cursor past the last cell");

    a_scroll_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.scrolled) |->
            ((CELLS > 2048) || (int'(o_out.cursor_position) >= CELLS - COLUMNS)))
        else $error("cursor not on the bottom row after a scroll");

endmodule

bind text_console_char_engine_unit tcce_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcce_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

// ===== bench/tb_text_console_char_engine_unit.sv =====
// Testbench for the text console character engine: checks every result against a screen model.
`timescale 1ns / 1ps

module tb_text_console_char_engine_unit;
    import tcce_pkg::*;

    localparam int SCREEN_COLS  = COLUMNS_DEF;
    localparam int SCREEN_ROWS  = ROWS_DEF;
    localparam int SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;
    localparam int QUIET_LIMIT  = 12000;
    localparam int HOLD_OFF_LEN = 250;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              o_in_stall;
    t_in_beat          in_beat = '0;
    logic              o_out_valid;
    logic              out_stall = 1'b0;
    t_out_beat         o_out;
    logic              cfg_we = 1'b0;
    logic [ATTR_W-1:0] cfg_wdata = '0;

    logic [CELL_W-1:0] screen_image [SCREEN_CELLS];
    int unsigned       cursor_image;
    logic [ATTR_W-1:0] attr_image;
    t_out_beat         pending_results [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off_cycles = 0;
    int mismatch_count = 0;
    int quiet_cycles = 0;

    text_console_char_engine_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out       (o_out),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic blank_screen_image();
        for (int i = 0; i < SCREEN_CELLS; i++) begin
            screen_image[IDX_W'(i)] = {attr_image, CODE_SPACE};
        end
    endtask

    task automatic advance_console(input t_in_beat b);
        t_out_beat         r;
        int unsigned       col;
        int unsigned       n;
        logic [CELL_W-1:0] blank;
        blank = {attr_image, CODE_SPACE};
        r = '0;
        case (b.kind)
            KIND_PUT: begin
                col = cursor_image % SCREEN_COLS;
                case (b.char_code)
                    CODE_BELL: begin
                    end
                    CODE_BS, CODE_DEL: begin
                        if (cursor_image != 0) begin
                            cursor_image--;
                            screen_image[IDX_W'(cursor_image)] = blank;
                        end
                    end
                    CODE_TAB: begin
                        n = 8 - (col % 8);
                        for (int unsigned i = 0; i < n; i++) begin
                            if (cursor_image + i < SCREEN_CELLS) begin
                                screen_image[IDX_W'(cursor_image + i)] = blank;
                            end
                        end
                        cursor_image += n;
                    end
                    CODE_CR: begin
                        cursor_image -= col;
                    end
                    CODE_LF: begin
                        cursor_image += SCREEN_COLS;
                    end
                    default: begin
                        if (cursor_image < SCREEN_CELLS) begin
                            screen_image[IDX_W'(cursor_image)] = {attr_image, b.char_code};
                        end
                        cursor_image++;
                    end
                endcase
                if (cursor_image >= SCREEN_CELLS) begin
                    cursor_image -= SCREEN_COLS;
                    for (int i = 0; i < SCREEN_CELLS - SCREEN_COLS; i++) begin
                        screen_image[IDX_W'(i)] = screen_image[IDX_W'(i + SCREEN_COLS)];
                    end
                    for (int i = SCREEN_CELLS - SCREEN_COLS; i < SCREEN_CELLS; i++) begin
                        screen_image[IDX_W'(i)] = blank;
                    end
                    r.scrolled = 1'b1;
                end
            end
            KIND_CLEAR: begin
                blank_screen_image();
                cursor_image = 0;
            end
            KIND_READ: begin
                if (int'(b.cell_index) < SCREEN_CELLS) begin
                    r.cell_data = screen_image[b.cell_index];
                end
            end
            default: begin
            end
        endcase
        r.cursor_position = cursor_image[CUR_W-1:0];
        pending_results.push_back(r);
    endtask

    function automatic t_in_beat make_beat(input logic [KIND_W-1:0] kind,
                                           input logic [CODE_W-1:0] code,
                                           input logic [IDX_W-1:0]  idx);
        t_in_beat b;
        b.kind       = kind;
        b.char_code  = code;
        b.cell_index = idx;
        return b;
    endfunction

    task automatic send_item(input t_in_beat b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        advance_console(b);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_attribute(input logic [ATTR_W-1:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we     <= 1'b0;
        attr_image  = value;
    endtask

    function automatic t_in_beat random_item();
        t_in_beat    b;
        int unsigned r;
        int unsigned lo;
        b = make_beat(KIND_PUT, CODE_W'($urandom_range(255)), IDX_W'($urandom_range(2047)));
        r = $urandom_range(99);
        if (r < 55) begin
        end else if (r < 60) begin
            b.char_code = CODE_LF;
        end else if (r < 65) begin
            b.char_code = CODE_CR;
        end else if (r < 71) begin
            b.char_code = CODE_TAB;
        end else if (r < 74) begin
            b.char_code = CODE_BS;
        end else if (r < 77) begin
            b.char_code = CODE_DEL;
        end else if (r < 79) begin
            b.char_code = CODE_BELL;
        end else if (r < 80) begin
            b.kind = KIND_CLEAR;
        end else if (r < 81) begin
            b.kind = KIND_UNUSED;
        end else begin
            b.kind = KIND_READ;
            r = $urandom_range(9);
            if (r < 4) begin
                lo = (cursor_image > 100) ? cursor_image - 100 : 0;
                b.cell_index = IDX_W'($urandom_range(cursor_image, lo));
            end else if (r < 9) begin
                b.cell_index = IDX_W'($urandom_range(SCREEN_CELLS - 1));
            end else begin
                b.cell_index = IDX_W'($urandom_range(2047, SCREEN_CELLS));
            end
        end
        return b;
    endfunction

    // check each beat taken from the output
    initial begin
        t_out_beat want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid === 1'b1 && !out_stall) begin
                if (pending_results.size() == 0) begin
                    flag_mismatch("unexpected beat", int'(o_out), 0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_out.cursor_position !== want.cursor_position)
                        flag_mismatch("cursor_position", int'(o_out.cursor_position),
                                      int'(want.cursor_position));
                    if (o_out.cell_data !== want.cell_data)
                        flag_mismatch("cell_data", int'(o_out.cell_data),
                                      int'(want.cell_data));
                    if (o_out.scrolled !== want.scrolled)
                        flag_mismatch("scrolled", int'(o_out.scrolled), int'(want.scrolled));
                end
            end
            if (hold_off_cycles > 0) begin
                out_stall <= 1'b1;
                hold_off_cycles--;
            end else begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic test_reset_and_home();
        send_item(make_beat(KIND_READ, 8'h00, 11'd0));
        send_item(make_beat(KIND_READ, 8'hFF, IDX_W'(SCREEN_CELLS - 1)));
        send_item(make_beat(KIND_READ, 8'h00, IDX_W'(SCREEN_CELLS)));
        send_item(make_beat(KIND_READ, 8'h00, 11'h7FF));
        send_item(make_beat(KIND_PUT, CODE_BS, 11'h7FF));
        send_item(make_beat(KIND_PUT, CODE_DEL, 11'd0));
        send_item(make_beat(KIND_PUT, CODE_BELL, 11'd0));
        send_item(make_beat(KIND_UNUSED, 8'hFF, 11'h7FF));
    endtask

    task automatic test_put_and_controls();
        write_attribute(8'hFF);
        send_item(make_beat(KIND_PUT, 8'h00, 11'd0));
        send_item(make_beat(KIND_PUT, 8'hFF, 11'd0));
        send_item(make_beat(KIND_PUT, 8'h41, 11'd0));
        send_item(make_beat(KIND_PUT, CODE_TAB, 11'd0));
        send_item(make_beat(KIND_PUT, CODE_LF, 11'd0));
        send_item(make_beat(KIND_PUT, CODE_BS, 11'd0));
        send_item(make_beat(KIND_PUT, CODE_DEL, 11'd0));
        send_item(make_beat(KIND_PUT, CODE_CR, 11'd0));
        send_item(make_beat(KIND_READ, 8'h00, 11'd1));
        send_item(make_beat(KIND_READ, 8'h00, 11'd2));
        send_item(make_beat(KIND_READ, 8'h00, 11'd7));
        send_item(make_beat(KIND_READ, 8'h00, 11'd86));
        write_attribute(8'h00);
        send_item(make_beat(KIND_CLEAR, 8'hFF, 11'h7FF));
        send_item(make_beat(KIND_READ, 8'h00, 11'd0));
        send_item(make_beat(KIND_READ, 8'h00, IDX_W'(SCREEN_CELLS - 1)));
    endtask

    task automatic test_backpressure();
        wait_drained();
        send_idle_pct   = 0;
        hold_off_cycles = HOLD_OFF_LEN;
        for (int i = 0; i < 16; i++) begin
            send_item(make_beat(KIND_PUT, CODE_W'($urandom_range(126, 32)), 11'd0));
        end
        wait_drained();
    endtask

    task automatic test_random(input int count, input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < count; i++) begin
            if (i % 200 == 199) begin
                write_attribute(ATTR_W'($urandom_range(255)));
            end
            send_item(random_item());
        end
        wait_drained();
    endtask

    initial begin
        attr_image   = ATTR_RESET;
        cursor_image = 0;
        blank_screen_image();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 13;
        recv_idle_pct = 59;
        test_reset_and_home();
        test_put_and_controls();
        test_backpressure();
        write_attribute(ATTR_RESET);
        test_random(600, 13, 59);
        test_random(600, 59, 13);
        write_attribute(8'hFF);
        test_random(600, 0, 0);
        repeat (20) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            flag_mismatch("results left over", pending_results.size(), 0);
        end
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/tcce_pkg.sv
rtl/core/tcce_sequencer.sv
rtl/core/tcce_datapath.sv
rtl/core/text_console_char_engine_unit.sv
rtl/core/tcce_checker.sv
bench/tb_text_console_char_engine_unit.sv
